[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the deque block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define DWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define DWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dws_pkg.sv]
// Package for the deque-with-search block: sizes, request and status codes,
// state type and the ring index helper. No dependencies.
package dws_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 5;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] K_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] K_REM_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] K_REM_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] K_SEARCH    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } dws_state_t;

  // Write and read port request towards the entry memory.
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  raddr;
  } ram_req_t;

  // Finished result of one request.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } res_t;

  // Slot that lies off places behind front, wrapped round the ring.
  // front < CAPACITY and off <= CAPACITY, so one subtract suffices.
  function automatic idx_t slot_of(idx_t front, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

endpackage

[rtl/dws_channels.sv]
// Request and result channel interfaces of the deque-with-search block.
// Depends on dws_pkg.
interface dws_req_if import dws_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dws_rsp_if import dws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

[rtl/dws_ram.sv]
// Entry memory of the deque: one write port, one read port, registered read.
// Depends on dws_pkg.
module dws_ram import dws_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output data_t    rd_data
);

  data_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

[rtl/dws_ctrl.sv]
// Request sequencer of the deque: front index, element count and the
// search walk over the entry memory. Depends on dws_pkg.
module dws_ctrl import dws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  data_t             in_value,
  output ram_req_t          ram_req,
  input  data_t             rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  dws_state_t        state_r, state_nxt;
  idx_t              front_r, front_nxt;
  cnt_t              count_r, count_nxt;
  cnt_t              idx_r, idx_nxt;
  data_t             key_r, key_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic is_full, is_empty, accept;
  cnt_t idx_inc;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign accept   = in_valid && in_ready;
  assign idx_inc  = idx_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = front_r;
    ram_req.wdata = in_value;
    ram_req.raddr = front_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          status_nxt = ST_OK;
          pos_nxt    = '0;
          state_nxt  = S_DONE;
          unique case (in_kind)
            K_INS_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                front_nxt     = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - IDX_W'(1);
                ram_req.we    = 1'b1;
                ram_req.waddr = front_nxt;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            K_INS_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(front_r, count_r);
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            K_REM_FRONT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                front_nxt = slot_of(front_r, CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end
            end
            K_REM_BACK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            K_SEARCH: begin
              if (is_empty) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                // The front entry is read now and compared next cycle.
                idx_nxt   = '0;
                key_nxt   = in_value;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // Unused kind codes change nothing and report success.
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at offset idx_r; the next one is fetched
        // ahead and simply dropped if the walk stops here.
        ram_req.raddr = slot_of(front_r, idx_inc);
        idx_nxt       = idx_inc;
        if (rd_data == key_r) begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(idx_inc);
          state_nxt  = S_DONE;
        end else if (idx_inc == count_r) begin
          status_nxt = ST_NOTFOUND;
          pos_nxt    = '0;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status   = status_r;
  assign res.position = pos_r;

endmodule

[rtl/deque_with_search_core.sv]
// Top level of the deque-with-search block: entry memory, sequencer and
// result register. Depends on dws_pkg, dws_channels, dws_ram and dws_ctrl.
//
// A bounded double-ended queue of CAPACITY signed 32-bit values held in a
// ring in one synchronous memory. Each request inserts at the front or back,
// removes from the front or back, or searches for a key, and each gives
// exactly one result with a status (ok, empty, full, not found) and, for a
// successful search, the 1-based position of the first match from the
// front. Requests are handled one at a time. An insert, a removal, an unused
// kind code or a search of an empty list is accepted, its result is registered
// in the sequencer and moves into the output register, which drives the result
// channel, as soon as that register is free; the block takes its next request
// the cycle after that result has moved into the output register. A search
// reads one stored entry per cycle through the single memory read port. The
// output register lets a new request be accepted while the previous result
// still waits for the sink. The memory needs no clearing after reset: only
// occupied slots are ever compared.
module deque_with_search_core import dws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dws_req_if.sink   in_ch,
  dws_rsp_if.source out_ch
);

  ram_req_t ram_req;
  data_t    rd_data;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [POS_W-1:0]  out_position_r;

  // The sequencer is the only writer and reader of the memory, and it never
  // uses read data of a slot that it wrote in the same cycle, so no forwarding
  // path is needed.
  dws_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .in_value  (data_t'(in_ch.value)),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The result register takes a new result whenever it is empty or is being
  // emptied in the same cycle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r   <= res.status;
      out_position_r <= res.position;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.position = out_position_r;

endmodule

[rtl/dws_checker.sv]
// Port-level checker for deque_with_search_core and its bind statement.
// Depends on dws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dws_checker import dws_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [POS_W-1:0]  out_position
);

  `DWS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DWS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_status) && $stable(out_position), "stalled result changed")
  `DWS_ASSERT(a_pos_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_position == '0, "position set on a failed request")
  `DWS_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken before the first finished")
  `DWS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result presented after reset")

endmodule

bind deque_with_search_core dws_checker u_dws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_position (out_ch.position)
);

[verif/dws_tb_pkg.sv]
// Testbench package for the deque-with-search block: spare request codes and
// the result tracker that predicts and checks every result. Depends on dws_pkg.
`timescale 1ns / 100ps

package dws_tb_pkg;
  import dws_pkg::*;

  // Request codes that the block accepts but ignores.
  localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

  class deque_tracker;
    // Private copy of the ring, its front slot and its fill level.
    data_t ring [CAPACITY];
    int    head;
    int    fill;
    res_t  pending_results [$];

    int mismatches;
    int requests;
    int full_hits;
    int empty_hits;
    int found_hits;
    int miss_hits;
    int spare_hits;

    function new();
      head       = 0;
      fill       = 0;
      mismatches = 0;
      requests   = 0;
      full_hits  = 0;
      empty_hits = 0;
      found_hits = 0;
      miss_hits  = 0;
      spare_hits = 0;
    endfunction

    // Applies one accepted request to the private ring and queues its result.
    function void note_request(logic [KIND_W-1:0] kind, data_t value);
      res_t res;
      bit   hit;
      res.status   = ST_OK;
      res.position = '0;
      hit          = 1'b0;
      requests++;
      case (kind)
        K_INS_FRONT: begin
          if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            head       = (head + CAPACITY - 1) % CAPACITY;
            ring[head] = value;
            fill++;
          end
        end
        K_INS_BACK: begin
          if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            ring[(head + fill) % CAPACITY] = value;
            fill++;
          end
        end
        K_REM_FRONT: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            head = (head + 1) % CAPACITY;
            fill--;
          end
        end
        K_REM_BACK: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            fill--;
          end
        end
        K_SEARCH: begin
          res.status = ST_NOTFOUND;
          for (int i = 0; i < fill; i++) begin
            if (!hit && ring[(head + i) % CAPACITY] == value) begin
              hit          = 1'b1;
              res.status   = ST_OK;
              res.position = POS_W'(i + 1);
            end
          end
          if (hit) found_hits++;
          else miss_hits++;
        end
        default: begin
          spare_hits++;
        end
      endcase
      if (res.status == ST_FULL) full_hits++;
      if (res.status == ST_EMPTY) empty_hits++;
      pending_results.push_back(res);
    endfunction

    // Compares one accepted result with the oldest outstanding prediction.
    function void check_result(logic [STAT_W-1:0] status, logic [POS_W-1:0] position);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual status %0d position %0d",
                 $time, status, position);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
      end
      if (position !== want.position) begin
        mismatches++;
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, position);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // A value currently held in the ring; only called when it is not empty.
    function data_t stored_value();
      return ring[(head + $urandom_range(fill - 1, 0)) % CAPACITY];
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
// Top level of the deque-with-search testbench: clock, reset, request and
// result drivers, watchdog and end-of-run report. Depends on dws_pkg,
// dws_channels, dws_tb_pkg and deque_with_search_core.
`timescale 1ns / 100ps

module tb_top;
  import dws_pkg::*;
  import dws_tb_pkg::*;

  // Cycles with no request or result moving before the run is declared hung.
  // The worst honest wait is the long receiver hold-off plus a full search.
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 385;
  localparam int DRAIN_CYCLES  = 2 * CAPACITY + 8;

  logic clk = 1'b0;
  logic rst_n;

  dws_req_if req_ch ();
  dws_rsp_if rsp_ch ();

  deque_with_search_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  deque_tracker tracker = new();

  // When set, neither side inserts gaps; used for stretches of full-rate
  // traffic and while the receiver holds off so that the block backs up.
  bit no_idle     = 1'b0;
  bit steady_feed = 1'b0;

  // A handful of values that recur, so that searches meet duplicates and the
  // extremes of the signed range keep turning up.
  data_t common_values [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length in cycles: mostly none, sometimes a few, rarely a long one.
  function automatic int pick_gap();
    int roll;
    if (no_idle || steady_feed) return 0;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic data_t pick_value();
    if ($urandom_range(3, 0) == 0) return common_values[$urandom_range(7, 0)];
    return $urandom;
  endfunction

  // Search keys favour values known to be in the list so that hits are common.
  function automatic data_t pick_key();
    if (tracker.fill > 0 && $urandom_range(1, 0) == 1) return tracker.stored_value();
    return pick_value();
  endfunction

  // Offers one request after a random gap and waits until the block takes it.
  // The valid line is only lowered when a gap follows, so back-to-back requests
  // keep it high across the edge.
  task automatic send_request(logic [KIND_W-1:0] kind, data_t value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(kind, value);
  endtask

  // Receiver: checks each accepted result and throttles ready. Once, after
  // enough requests have been accepted, it holds ready low for a long stretch while
  // the sender keeps offering requests back to back.
  initial begin
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_result(rsp_ch.status, rsp_ch.position);
      end
      if (!held_off && tracker.requests >= 120) begin
        held_off     = 1'b1;
        steady_feed  = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        steady_feed  = 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: the run is hung if nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int                counted;
    int                mode;
    int                span;
    int                roll;
    int                insert_share;
    logic [KIND_W-1:0] kind;
    data_t             value;

    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= K_INS_FRONT;
    req_ch.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Removals and a search on an empty list come first, then
    // the ignored codes, the signed extremes at both ends, a first and a
    // second position hit, a miss, and removal of the only element.
    send_request(K_REM_FRONT, 32'h0000_0000);
    send_request(K_REM_BACK, 32'hFFFF_FFFF);
    send_request(K_SEARCH, 32'h0000_0000);
    for (int code = K_SPARE_FIRST; code <= K_SPARE_LAST; code++) begin
      send_request(KIND_W'(code), 32'h1234_5678);
    end
    send_request(K_INS_BACK, 32'h7FFF_FFFF);
    send_request(K_INS_FRONT, 32'h8000_0000);
    send_request(K_SEARCH, 32'h8000_0000);
    send_request(K_SEARCH, 32'h7FFF_FFFF);
    send_request(K_SEARCH, 32'hFFFF_FFFF);
    send_request(K_INS_BACK, 32'h8000_0000);
    send_request(K_SEARCH, 32'h8000_0000);
    send_request(K_REM_BACK, 32'h0000_0000);
    send_request(K_REM_FRONT, 32'h0000_0000);
    send_request(K_REM_FRONT, 32'h0000_0000);
    send_request(K_INS_FRONT, 32'h0000_0000);
    send_request(K_REM_BACK, 32'h0000_0000);
    send_request(K_SEARCH, 32'h0000_0000);
    send_request(K_REM_BACK, 32'h0000_0000);

    // Random part in episodes: filling runs drive the list to full and past
    // it, draining runs empty it and keep removing, mixed runs sit between.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode    = $urandom_range(2, 0);
      span    = $urandom_range(40, 15);
      no_idle = ($urandom_range(5, 0) == 0);
      insert_share = (mode == 0) ? 95 : (mode == 1) ? 5 : 50;
      repeat (span) begin
        roll = $urandom_range(99, 0);
        if (roll < 3) begin
          kind  = KIND_W'($urandom_range(K_SPARE_LAST, K_SPARE_FIRST));
          value = $urandom;
        end else if (roll < 20) begin
          kind  = K_SEARCH;
          value = pick_key();
        end else if ($urandom_range(99, 0) < insert_share) begin
          kind  = $urandom_range(1, 0) ? K_INS_BACK : K_INS_FRONT;
          value = pick_value();
        end else begin
          kind  = $urandom_range(1, 0) ? K_REM_BACK : K_REM_FRONT;
          value = $urandom;
        end
        send_request(kind, value);
        if (kind <= K_SEARCH) counted++;
      end
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    // Let every outstanding result arrive, then allow time for a stray one.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d full inserts, %0d empty removals,",
             tracker.requests, tracker.full_hits, tracker.empty_hits);
    $display("%0d search hits, %0d search misses, %0d ignored codes, %0d mismatches.",
             tracker.found_hits, tracker.miss_hits, tracker.spare_hits, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
